// File: rtl/mp3_huffman_pair_quad_decoder_macros.svh
// Assertion macros used by the decoder checker.
`ifndef MP3_HUFFMAN_PAIR_QUAD_DECODER_MACROS_SVH
`define MP3_HUFFMAN_PAIR_QUAD_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MHPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder assertion failed");

// Next-cycle implication, disabled while reset is low.
`define MHPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder assertion failed");

`endif

// File: rtl/mhpq_pkg.sv
// Types, codes and tree ROM contents for the pair/quadruple Huffman decoder.
package mhpq_pkg;

    localparam int N_VALS = 4;

    localparam logic OP_PAIR = 1'b0;
    localparam logic OP_QUAD = 1'b1;

    localparam logic [1:0] TBL_ZERO  = 2'd0;
    localparam logic [1:0] TBL_TWO   = 2'd2;
    localparam logic [1:0] TBL_THREE = 2'd3;

    localparam logic [1:0] ROM_BV1 = 2'd0;
    localparam logic [1:0] ROM_BV2 = 2'd1;
    localparam logic [1:0] ROM_C1A = 2'd2;
    localparam logic [1:0] ROM_C1B = 2'd3;

    typedef logic signed [2:0] t_sample;

    typedef struct packed {
        logic       operation;
        logic [1:0] table_index;
        logic       bit_req;
        logic       has_bit;
    } t_in_item;

    typedef struct packed {
        logic signed [2:0] sample;
        logic              last;
    } t_out_item;

    // Results of one codeword handed from the core to the output buffer.
    typedef struct packed {
        logic                     load;
        logic [2:0]               count;
        t_sample [N_VALS-1:0]     vals;
    } t_burst;

    // Branch nodes hold offsets in a and b, leaves hold magnitudes in a..d.
    typedef struct packed {
        logic       leaf;
        logic [4:0] a;
        logic [4:0] b;
        logic [1:0] c;
        logic [1:0] d;
    } t_node;

    function automatic t_node br(input logic [4:0] off);
        t_node n;
        n = '0;
        n.a = 5'd1;
        n.b = off;
        return n;
    endfunction

    function automatic t_node lp(input logic [1:0] x, input logic [1:0] y);
        t_node n;
        n = '0;
        n.leaf = 1'b1;
        n.a = {3'b000, x};
        n.b = {3'b000, y};
        return n;
    endfunction

    // Quadruple leaf, magnitudes given msb first as a, b, c, d.
    function automatic t_node lq(input logic [3:0] q);
        t_node n;
        n = '0;
        n.leaf = 1'b1;
        n.a = {4'b0000, q[3]};
        n.b = {4'b0000, q[2]};
        n.c = {1'b0, q[1]};
        n.d = {1'b0, q[0]};
        return n;
    endfunction

    function automatic t_node rom_node(input logic [1:0] id, input logic [4:0] pos);
        t_node n;
        n = '0;
        unique case (id)
            ROM_BV1: begin
                unique case (pos)
                    5'd0: n = br(5'd6);
                    5'd1: n = br(5'd4);
                    5'd2: n = br(5'd2);
                    5'd3: n = lp(2'd1, 2'd1);
                    5'd4: n = lp(2'd0, 2'd1);
                    5'd5: n = lp(2'd1, 2'd0);
                    5'd6: n = lp(2'd0, 2'd0);
                    default: n = '0;
                endcase
            end
            ROM_BV2: begin
                unique case (pos)
                    5'd0:  n = br(5'd16);
                    5'd1:  n = br(5'd12);
                    5'd2:  n = br(5'd10);
                    5'd3:  n = br(5'd6);
                    5'd4:  n = br(5'd4);
                    5'd5:  n = br(5'd2);
                    5'd6:  n = lp(2'd2, 2'd2);
                    5'd7:  n = lp(2'd0, 2'd2);
                    5'd8:  n = lp(2'd1, 2'd2);
                    5'd9:  n = br(5'd2);
                    5'd10: n = lp(2'd2, 2'd1);
                    5'd11: n = lp(2'd2, 2'd0);
                    5'd12: n = lp(2'd1, 2'd1);
                    5'd13: n = br(5'd2);
                    5'd14: n = lp(2'd0, 2'd1);
                    5'd15: n = lp(2'd1, 2'd0);
                    5'd16: n = lp(2'd0, 2'd0);
                    default: n = '0;
                endcase
            end
            ROM_C1A: begin
                unique case (pos)
                    5'd0:  n = br(5'd30);
                    5'd1:  n = br(5'd22);
                    5'd2:  n = br(5'd14);
                    5'd3:  n = br(5'd8);
                    5'd4:  n = br(5'd4);
                    5'd5:  n = br(5'd2);
                    5'd6:  n = lq(4'b1011);
                    5'd7:  n = lq(4'b1111);
                    5'd8:  n = br(5'd2);
                    5'd9:  n = lq(4'b1101);
                    5'd10: n = lq(4'b1110);
                    5'd11: n = br(5'd4);
                    5'd12: n = br(5'd2);
                    5'd13: n = lq(4'b0111);
                    5'd14: n = lq(4'b0101);
                    5'd15: n = lq(4'b1001);
                    5'd16: n = br(5'd4);
                    5'd17: n = br(5'd2);
                    5'd18: n = lq(4'b0110);
                    5'd19: n = lq(4'b0011);
                    5'd20: n = br(5'd2);
                    5'd21: n = lq(4'b1010);
                    5'd22: n = lq(4'b1100);
                    5'd23: n = br(5'd4);
                    5'd24: n = br(5'd2);
                    5'd25: n = lq(4'b0010);
                    5'd26: n = lq(4'b0001);
                    5'd27: n = br(5'd2);
                    5'd28: n = lq(4'b0100);
                    5'd29: n = lq(4'b1000);
                    5'd30: n = lq(4'b0000);
                    default: n = '0;
                endcase
            end
            ROM_C1B: begin
                unique case (pos)
                    5'd0:  n = br(5'd16);
                    5'd1:  n = br(5'd8);
                    5'd2:  n = br(5'd4);
                    5'd3:  n = br(5'd2);
                    5'd4:  n = lq(4'b1111);
                    5'd5:  n = lq(4'b1110);
                    5'd6:  n = br(5'd2);
                    5'd7:  n = lq(4'b1101);
                    5'd8:  n = lq(4'b1100);
                    5'd9:  n = br(5'd4);
                    5'd10: n = br(5'd2);
                    5'd11: n = lq(4'b1011);
                    5'd12: n = lq(4'b1010);
                    5'd13: n = br(5'd2);
                    5'd14: n = lq(4'b1001);
                    5'd15: n = lq(4'b1000);
                    5'd16: n = br(5'd8);
                    5'd17: n = br(5'd4);
                    5'd18: n = br(5'd2);
                    5'd19: n = lq(4'b0111);
                    5'd20: n = lq(4'b0110);
                    5'd21: n = br(5'd2);
                    5'd22: n = lq(4'b0101);
                    5'd23: n = lq(4'b0100);
                    5'd24: n = br(5'd4);
                    5'd25: n = br(5'd2);
                    5'd26: n = lq(4'b0011);
                    5'd27: n = lq(4'b0010);
                    5'd28: n = br(5'd2);
                    5'd29: n = lq(4'b0001);
                    5'd30: n = lq(4'b0000);
                    default: n = '0;
                endcase
            end
            default: n = '0;
        endcase
        return n;
    endfunction

endpackage

// File: rtl/mhpq_core.sv
// Codeword state machine: tree walk, sign bits and result bundling.
module mhpq_core
    import mhpq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    input  t_in_item i_req,
    input  logic     i_buf_free,
    output logic     o_take,
    output t_burst   o_burst
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WALK = 2'd1;
    localparam logic [1:0] PH_SIGN = 2'd2;

    logic [1:0]           r_phase, n_phase;
    logic [4:0]           r_tp, n_tp;
    logic [1:0]           r_slot, n_slot;
    logic                 r_op, n_op;
    logic [1:0]           r_tb, n_tb;
    t_sample [N_VALS-1:0] r_held, n_held;

    logic                 idle;
    logic                 zero_start;
    logic                 do_walk;
    logic                 do_sign;
    logic                 e_op;
    logic [1:0]           e_tb;
    logic [1:0]           rom_id;
    logic [2:0]           cnt;
    logic [4:0]           tp_cur;
    logic [4:0]           nxt;
    t_node                cur;
    t_node                nn;
    t_sample [N_VALS-1:0] lv;
    t_sample [N_VALS-1:0] sv;
    t_sample [N_VALS-1:0] ev;
    logic [2:0]           s_leaf;
    logic [2:0]           s_sign;
    logic                 emit;

    // Index of the first nonzero value at or above from, or cnt if none.
    function automatic logic [2:0] first_nz(input t_sample [N_VALS-1:0] v,
                                            input logic [2:0] from,
                                            input logic [2:0] cnt_in);
        logic [2:0] r;
        r = cnt_in;
        for (int i = N_VALS - 1; i >= 0; i--) begin
            if (i >= int'(from) && i < int'(cnt_in) && v[i] != 3'sd0) begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

    assign idle       = (r_phase == PH_IDLE);
    assign zero_start = idle && (i_req.operation == OP_PAIR)
                        && (i_req.table_index == TBL_ZERO || i_req.table_index == TBL_THREE);
    assign do_walk    = i_req.has_bit && ((idle && !zero_start) || r_phase == PH_WALK);
    assign do_sign    = i_req.has_bit && (r_phase == PH_SIGN);

    // Operation and table come from the request only at codeword start.
    assign e_op   = idle ? i_req.operation : r_op;
    assign e_tb   = idle ? i_req.table_index : r_tb;
    assign rom_id = (e_op == OP_QUAD) ? {1'b1, e_tb[0]}
                  : ((e_tb == TBL_TWO) ? ROM_BV2 : ROM_BV1);
    assign cnt    = (e_op == OP_QUAD) ? 3'd4 : 3'd2;

    assign tp_cur = idle ? 5'd0 : r_tp;
    assign cur    = rom_node(rom_id, tp_cur);
    assign nxt    = tp_cur + (i_req.bit_req ? cur.b : cur.a);
    assign nn     = rom_node(rom_id, nxt);

    assign lv[0] = {1'b0, nn.a[1:0]};
    assign lv[1] = {1'b0, nn.b[1:0]};
    assign lv[2] = {1'b0, nn.c};
    assign lv[3] = {1'b0, nn.d};

    always_comb begin
        sv = r_held;
        if (i_req.bit_req) begin
            sv[r_slot] = -r_held[r_slot];
        end
    end

    assign s_leaf = first_nz(lv, 3'd0, cnt);
    assign s_sign = first_nz(sv, {1'b0, r_slot} + 3'd1, cnt);

    always_comb begin
        n_phase = r_phase;
        n_tp    = r_tp;
        n_slot  = r_slot;
        n_op    = r_op;
        n_tb    = r_tb;
        n_held  = r_held;
        emit    = 1'b0;
        ev      = r_held;
        priority if (zero_start) begin
            n_op   = i_req.operation;
            n_tb   = i_req.table_index;
            n_held = '0;
            ev     = '0;
            emit   = 1'b1;
        end else if (do_walk) begin
            n_op    = e_op;
            n_tb    = e_tb;
            n_tp    = nxt;
            n_phase = PH_WALK;
            if (nn.leaf) begin
                n_held = lv;
                if (s_leaf == cnt) begin
                    emit = 1'b1;
                    ev   = lv;
                end else begin
                    n_slot  = s_leaf[1:0];
                    n_phase = PH_SIGN;
                end
            end
        end else if (do_sign) begin
            n_held = sv;
            if (s_sign == cnt) begin
                emit = 1'b1;
                ev   = sv;
            end else begin
                n_slot = s_sign[1:0];
            end
        end else if (i_req.has_bit && !idle && r_phase != PH_WALK && r_phase != PH_SIGN) begin
            n_phase = PH_IDLE;
            n_tp    = 5'd0;
        end
        if (emit) begin
            n_phase = PH_IDLE;
            n_tp    = 5'd0;
            n_slot  = 2'd0;
        end
    end

    // Hold a result-producing request until the output buffer has room.
    assign o_take        = i_req_valid && (!emit || i_buf_free);
    assign o_burst.load  = o_take && emit;
    assign o_burst.count = cnt;
    assign o_burst.vals  = ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tp    <= 5'd0;
            r_slot  <= 2'd0;
            r_op    <= OP_PAIR;
            r_tb    <= TBL_ZERO;
        end else if (o_take) begin
            r_phase <= n_phase;
            r_tp    <= n_tp;
            r_slot  <= n_slot;
            r_op    <= n_op;
            r_tb    <= n_tb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_held <= n_held;
        end
    end

endmodule

// File: rtl/mhpq_outbuf.sv
// Output buffer: holds one codeword's samples and sends them one per cycle while i_smp_ready is high.
module mhpq_outbuf
    import mhpq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_burst    i_burst,
    output logic      o_buf_free,
    output logic      o_smp_valid,
    input  logic      i_smp_ready,
    output t_out_item o_smp
);

    t_sample [N_VALS-1:0] r_vals;
    logic [2:0]           r_rem;
    logic [1:0]           r_idx;
    logic                 pop;

    assign pop         = (r_rem != 3'd0) && i_smp_ready;
    assign o_buf_free  = (r_rem == 3'd0) || (r_rem == 3'd1 && i_smp_ready);
    assign o_smp_valid = (r_rem != 3'd0);
    assign o_smp.sample = r_vals[r_idx];
    assign o_smp.last   = (r_rem == 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 3'd0;
            r_idx <= 2'd0;
        end else if (i_burst.load) begin
            r_rem <= i_burst.count;
            r_idx <= 2'd0;
        end else if (pop) begin
            r_rem <= r_rem - 3'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_burst.load) begin
            r_vals <= i_burst.vals;
        end
    end

endmodule

// File: rtl/mp3_huffman_pair_quad_decoder.sv
// Top level of the MP3 pair/quadruple Huffman decoder.
// Timing: an accepted request is registered in the input stage, and the core updates the codeword state
// from it when taken; a finished codeword is loaded into the output buffer, which then offers its first sample.
// Throughput: one request per cycle unless stalled; a codeword's 2 or 4 samples leave one per cycle while
// i_smp_ready is high, and a request that finishes a codeword waits while the output buffer is full.
// Reset: synchronous active-low i_rst_n clears the input stage, walk state and buffer.
module mp3_huffman_pair_quad_decoder
    import mhpq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    output logic      o_req_ready,
    input  t_in_item  i_req,
    output logic      o_smp_valid,
    input  logic      i_smp_ready,
    output t_out_item o_smp
);

    logic     r_in_valid;
    t_in_item r_in;
    logic     take;
    logic     buf_free;
    t_burst   burst;

    assign o_req_ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req_valid && o_req_ready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_in <= i_req;
        end
    end

    mhpq_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (r_in_valid),
        .i_req       (r_in),
        .i_buf_free  (buf_free),
        .o_take      (take),
        .o_burst     (burst)
    );

    mhpq_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_burst     (burst),
        .o_buf_free  (buf_free),
        .o_smp_valid (o_smp_valid),
        .i_smp_ready (i_smp_ready),
        .o_smp       (o_smp)
    );

endmodule

// File: rtl/mhpq_checker.sv
// Port-level checker for the decoder, bound to the top level.
`include "mp3_huffman_pair_quad_decoder_macros.svh"

module mhpq_checker
    import mhpq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_req_valid,
    input logic      o_req_ready,
    input t_in_item  i_req,
    input logic      o_smp_valid,
    input logic      i_smp_ready,
    input t_out_item o_smp
);

    logic req_stall;
    logic smp_stall;
    logic smp_pop;
    logic smp_in_range;

    assign req_stall    = i_req_valid && !o_req_ready;
    assign smp_stall    = o_smp_valid && !i_smp_ready;
    assign smp_pop      = o_smp_valid && i_smp_ready;
    assign smp_in_range = (o_smp.sample >= -3'sd2) && (o_smp.sample <= 3'sd2);

    // A stalled request holds.
    `MHPQ_ASSERT_NEXT(a_req_hold, i_clk, i_rst_n, req_stall, i_req_valid && $stable(i_req))

    // A stalled sample holds.
    `MHPQ_ASSERT_NEXT(a_smp_hold, i_clk, i_rst_n, smp_stall, o_smp_valid && $stable(o_smp))

    // Samples stay within -2..2.
    `MHPQ_ASSERT_NOW(a_smp_range, i_clk, i_rst_n, o_smp_valid, smp_in_range)

    // A codeword never ends early: more samples follow a non-final one.
    `MHPQ_ASSERT_NEXT(a_burst_cont, i_clk, i_rst_n, smp_pop && !o_smp.last, o_smp_valid)

    // Nothing is offered right after reset.
    `MHPQ_ASSERT_NOW(a_reset_quiet, i_clk, i_rst_n, !$past(i_rst_n), !o_smp_valid)

endmodule

bind mp3_huffman_pair_quad_decoder mhpq_checker u_mhpq_checker (.*);
